[hdl/pcrm_pkg.sv]
package pcrm_pkg;

    localparam int ENTRIES     = 16;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TREE_N      = 1 << IDX_W;
    localparam int LVLS        = IDX_W;
    localparam int SPLIT       = (IDX_W + 1) / 2;
    localparam int MID_N       = TREE_N >> SPLIT;
    localparam int FIELD_IDX_W = 4;
    localparam int CH_W        = 8;
    localparam int RGB_W       = 3 * CH_W;
    localparam int SQ_W        = 2 * CH_W;
    localparam int DIST_W      = SQ_W + 2;
    localparam logic [CH_W-1:0] MAX_DIST_RST = 8'd8;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_EXACT = 2'd1,
        OP_NEAR  = 2'd2
    } op_t;

    typedef logic [RGB_W-1:0]  rgb_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DIST_W-1:0] dist_t;
    typedef logic [CH_W-1:0]   chan_t;
    typedef logic [SQ_W-1:0]   sq_t;

    typedef struct packed {
        op_t                    op;
        logic [FIELD_IDX_W-1:0] index;
        rgb_t                   rgb;
        rgb_t                   new_rgb;
    } item_t;

    typedef struct packed {
        logic hit;
        idx_t idx;
    } exact_t;

    typedef struct packed {
        item_t  item;
        exact_t exact;
        idx_t   best_idx;
        dist_t  best_d;
    } match_t;

    function automatic chan_t abs_diff(input chan_t a, input chan_t b);
        chan_t d;
        if (a > b)
        begin
            d = a - b;
        end
        else
        begin
            d = b - a;
        end
        return d;
    endfunction

    function automatic logic index_ok(input logic [FIELD_IDX_W-1:0] index);
        return int'(index) < ENTRIES;
    endfunction

endpackage

[hdl/pcrm_if.sv]
interface pcrm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [3:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] new_red;
    logic [7:0] new_green;
    logic [7:0] new_blue;

    modport source (
        output valid, op, index, red, green, blue, new_red, new_green, new_blue,
        input  ready
    );
    modport sink (
        input  valid, op, index, red, green, blue, new_red, new_green, new_blue,
        output ready
    );
endinterface

interface pcrm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       hit;

    modport source (
        output valid, out_red, out_green, out_blue, hit,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, hit,
        output ready
    );
endinterface

interface pcrm_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] max_distance;

    modport source (
        output valid, max_distance,
        input  ready
    );
    modport sink (
        input  valid, max_distance,
        output ready
    );
endinterface

[hdl/palette_color_replace_match.sv]
// palette colour replacement with exact and nearest lookup
//
// pixel: input beats, valid/ready. op write stores a base and replacement
// colour at index and gives no result; op exact and op near each give one
// result beat; the unused op code gives nothing.
// result: output beats, valid/ready, replacement colour and hit, or the
// input colour with hit low on a miss.
// cfg: max_distance writes, always ready; it is to be written only while the
// block is idle, which the user must ensure; the block does not enforce it.
// throughput: one beat per cycle while result is not stalled; seven register
// stages (input, lane compare, channel squares, distance sum, two halves of the
// minimum tree, output). a write updates the base table as it leaves stage 1
// and the replacement table as it leaves stage 6, so every later beat sees it.
// reset clears both tables and the pipeline and sets max_distance to 8.
// when result is stalled, empty stages still fill; pixel.ready falls only
// once all seven stages hold a beat.
module palette_color_replace_match
    import pcrm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pcrm_in_if.sink     pixel,
    pcrm_out_if.source  result,
    pcrm_cfg_if.sink    cfg
);

    logic   v4, rdy4, v6, rdy6;
    item_t  item4;
    exact_t exact4;
    dist_t  dist4 [ENTRIES];
    match_t match6;

    logic   v7_reg;
    rgb_t   out_rgb_reg, out_rgb_next;
    logic   hit_reg, hit_next, emit_next;
    rgb_t   repl_reg [ENTRIES];
    logic   repl_we, load7;
    idx_t   sel_idx;
    chan_t  max_distance_reg;
    sq_t    max_sq_reg;

    pcrm_lanes u_lanes (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .down_ready (rdy4),
        .down_valid (v4),
        .down_item  (item4),
        .down_exact (exact4),
        .down_dist  (dist4)
    );

    pcrm_min_tree u_min_tree (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (v4),
        .up_ready   (rdy4),
        .up_item    (item4),
        .up_exact   (exact4),
        .up_dist    (dist4),
        .down_valid (v6),
        .down_ready (rdy6),
        .down_match (match6)
    );

    assign rdy6  = !v7_reg || result.ready;
    assign load7 = v6 && rdy6;

    always_comb
    begin
        emit_next = 1'b0;
        hit_next  = 1'b0;
        sel_idx   = match6.best_idx;
        repl_we   = 1'b0;
        case (match6.item.op)
            OP_WRITE:
            begin
                repl_we = load7 && index_ok(match6.item.index);
            end
            OP_EXACT:
            begin
                emit_next = 1'b1;
                hit_next  = match6.exact.hit;
                sel_idx   = match6.exact.idx;
            end
            OP_NEAR:
            begin
                emit_next = 1'b1;
                hit_next  = match6.best_d <= DIST_W'(max_sq_reg);
            end
            default:
            begin
                emit_next = 1'b0;
            end
        endcase
        out_rgb_next = hit_next ? repl_reg[sel_idx] : match6.item.rgb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else if (rdy6)
        begin
            v7_reg <= v6 && emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load7)
        begin
            out_rgb_reg <= out_rgb_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < ENTRIES; e++)
            begin
                repl_reg[e] <= '0;
            end
        end
        else if (repl_we)
        begin
            repl_reg[IDX_W'(match6.item.index)] <= match6.item.new_rgb;
        end
    end

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_distance_reg <= MAX_DIST_RST;
            max_sq_reg       <= SQ_W'(MAX_DIST_RST) * SQ_W'(MAX_DIST_RST);
        end
        else if (cfg.valid)
        begin
            max_distance_reg <= cfg.max_distance;
            max_sq_reg       <= SQ_W'(cfg.max_distance) * SQ_W'(cfg.max_distance);
        end
    end

    assign result.valid     = v7_reg;
    assign result.out_red   = out_rgb_reg[RGB_W-1 -: CH_W];
    assign result.out_green = out_rgb_reg[2*CH_W-1 -: CH_W];
    assign result.out_blue  = out_rgb_reg[CH_W-1:0];
    assign result.hit       = hit_reg;

    a_full_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> (result.valid && !result.ready))
        else $error("pixel stalled while output free");

    a_max_sq_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        max_sq_reg == SQ_W'(SQ_W'(max_distance_reg) * SQ_W'(max_distance_reg)))
        else $error("max distance square out of step");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        v6 |-> (int'(match6.best_idx) < ENTRIES))
        else $error("nearest entry past table");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        repl_we |=> !v7_reg)
        else $error("write beat produced a result");

endmodule

[hdl/pcrm_lanes.sv]
module pcrm_lanes
    import pcrm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pcrm_in_if.sink      pixel,
    input  logic         down_ready,
    output logic         down_valid,
    output item_t        down_item,
    output exact_t       down_exact,
    output dist_t        down_dist [ENTRIES]
);

    logic   v1_reg, v2_reg, v3_reg, v4_reg;
    logic   acc1, acc2, acc3, acc4;
    item_t  it1_reg, it2_reg, it3_reg, it4_reg;
    item_t  it1_next;
    rgb_t   base_reg [ENTRIES];
    logic   base_we;

    chan_t  dr_reg [ENTRIES];
    chan_t  dg_reg [ENTRIES];
    chan_t  db_reg [ENTRIES];
    chan_t  dr_next [ENTRIES];
    chan_t  dg_next [ENTRIES];
    chan_t  db_next [ENTRIES];
    logic [ENTRIES-1:0] eq2_reg, eq3_reg, eq_next;

    sq_t    sr_reg [ENTRIES];
    sq_t    sg_reg [ENTRIES];
    sq_t    sb_reg [ENTRIES];
    sq_t    sr_next [ENTRIES];
    sq_t    sg_next [ENTRIES];
    sq_t    sb_next [ENTRIES];

    dist_t  dist_reg [ENTRIES];
    dist_t  dist_next [ENTRIES];
    exact_t exact_reg, exact_next;

    assign acc4 = !v4_reg || down_ready;
    assign acc3 = !v3_reg || acc4;
    assign acc2 = !v2_reg || acc3;
    assign acc1 = !v1_reg || acc2;
    assign pixel.ready = acc1;

    assign it1_next.op      = op_t'(pixel.op);
    assign it1_next.index   = pixel.index;
    assign it1_next.rgb     = {pixel.red, pixel.green, pixel.blue};
    assign it1_next.new_rgb = {pixel.new_red, pixel.new_green, pixel.new_blue};

    // base table is read while a beat leaves stage 1, so writes keep beat order
    assign base_we = v1_reg && acc2 && (it1_reg.op == OP_WRITE) && index_ok(it1_reg.index);

    always_comb
    begin
        for (int e = 0; e < ENTRIES; e++)
        begin
            dr_next[e] = abs_diff(base_reg[e][RGB_W-1 -: CH_W], it1_reg.rgb[RGB_W-1 -: CH_W]);
            dg_next[e] = abs_diff(base_reg[e][2*CH_W-1 -: CH_W], it1_reg.rgb[2*CH_W-1 -: CH_W]);
            db_next[e] = abs_diff(base_reg[e][CH_W-1:0], it1_reg.rgb[CH_W-1:0]);
            eq_next[e] = (base_reg[e] == it1_reg.rgb);
        end
    end

    always_comb
    begin
        for (int e = 0; e < ENTRIES; e++)
        begin
            sr_next[e] = SQ_W'(dr_reg[e]) * SQ_W'(dr_reg[e]);
            sg_next[e] = SQ_W'(dg_reg[e]) * SQ_W'(dg_reg[e]);
            sb_next[e] = SQ_W'(db_reg[e]) * SQ_W'(db_reg[e]);
        end
    end

    always_comb
    begin
        exact_next.hit = 1'b0;
        exact_next.idx = '0;
        for (int e = 0; e < ENTRIES; e++)
        begin
            dist_next[e] = DIST_W'(sr_reg[e]) + DIST_W'(sg_reg[e]) + DIST_W'(sb_reg[e]);
        end
        for (int e = ENTRIES - 1; e >= 0; e--)
        begin
            if (eq3_reg[e])
            begin
                exact_next.hit = 1'b1;
                exact_next.idx = IDX_W'(e);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (acc1)
            begin
                v1_reg <= pixel.valid;
            end
            if (acc2)
            begin
                v2_reg <= v1_reg;
            end
            if (acc3)
            begin
                v3_reg <= v2_reg;
            end
            if (acc4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < ENTRIES; e++)
            begin
                base_reg[e] <= '0;
            end
        end
        else if (base_we)
        begin
            base_reg[IDX_W'(it1_reg.index)] <= it1_reg.rgb;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc1 && pixel.valid)
        begin
            it1_reg <= it1_next;
        end
        if (acc2 && v1_reg)
        begin
            it2_reg <= it1_reg;
            dr_reg  <= dr_next;
            dg_reg  <= dg_next;
            db_reg  <= db_next;
            eq2_reg <= eq_next;
        end
        if (acc3 && v2_reg)
        begin
            it3_reg <= it2_reg;
            sr_reg  <= sr_next;
            sg_reg  <= sg_next;
            sb_reg  <= sb_next;
            eq3_reg <= eq2_reg;
        end
        if (acc4 && v3_reg)
        begin
            it4_reg   <= it3_reg;
            dist_reg  <= dist_next;
            exact_reg <= exact_next;
        end
    end

    assign down_valid = v4_reg;
    assign down_item  = it4_reg;
    assign down_exact = exact_reg;
    assign down_dist  = dist_reg;

endmodule

[hdl/pcrm_min_tree.sv]
module pcrm_min_tree
    import pcrm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   up_valid,
    output logic   up_ready,
    input  item_t  up_item,
    input  exact_t up_exact,
    input  dist_t  up_dist [ENTRIES],
    output logic   down_valid,
    input  logic   down_ready,
    output match_t down_match
);

    logic   v5_reg, v6_reg;
    logic   acc5, acc6;
    item_t  it5_reg;
    exact_t exact5_reg;
    dist_t  mid_d_reg [MID_N];
    idx_t   mid_i_reg [MID_N];
    dist_t  mid_d_next [MID_N];
    idx_t   mid_i_next [MID_N];
    dist_t  l1_d [SPLIT+1][TREE_N];
    idx_t   l1_i [SPLIT+1][TREE_N];
    dist_t  l2_d [LVLS-SPLIT+1][MID_N];
    idx_t   l2_i [LVLS-SPLIT+1][MID_N];
    match_t match_reg, match_next;

    assign acc6     = !v6_reg || down_ready;
    assign acc5     = !v5_reg || acc6;
    assign up_ready = acc5;

    // ties keep the lower entry
    always_comb
    begin
        for (int l = 0; l <= SPLIT; l++)
        begin
            for (int j = 0; j < TREE_N; j++)
            begin
                l1_d[l][j] = '0;
                l1_i[l][j] = '0;
            end
        end
        for (int j = 0; j < TREE_N; j++)
        begin
            l1_d[0][j] = (j < ENTRIES) ? up_dist[j] : '1;
            l1_i[0][j] = IDX_W'(j);
        end
        for (int l = 0; l < SPLIT; l++)
        begin
            for (int j = 0; j < (TREE_N >> (l + 1)); j++)
            begin
                if (l1_d[l][2*j+1] < l1_d[l][2*j])
                begin
                    l1_d[l+1][j] = l1_d[l][2*j+1];
                    l1_i[l+1][j] = l1_i[l][2*j+1];
                end
                else
                begin
                    l1_d[l+1][j] = l1_d[l][2*j];
                    l1_i[l+1][j] = l1_i[l][2*j];
                end
            end
        end
        for (int j = 0; j < MID_N; j++)
        begin
            mid_d_next[j] = l1_d[SPLIT][j];
            mid_i_next[j] = l1_i[SPLIT][j];
        end
    end

    always_comb
    begin
        for (int l = 0; l <= LVLS - SPLIT; l++)
        begin
            for (int j = 0; j < MID_N; j++)
            begin
                l2_d[l][j] = '0;
                l2_i[l][j] = '0;
            end
        end
        for (int j = 0; j < MID_N; j++)
        begin
            l2_d[0][j] = mid_d_reg[j];
            l2_i[0][j] = mid_i_reg[j];
        end
        for (int l = 0; l < LVLS - SPLIT; l++)
        begin
            for (int j = 0; j < (MID_N >> (l + 1)); j++)
            begin
                if (l2_d[l][2*j+1] < l2_d[l][2*j])
                begin
                    l2_d[l+1][j] = l2_d[l][2*j+1];
                    l2_i[l+1][j] = l2_i[l][2*j+1];
                end
                else
                begin
                    l2_d[l+1][j] = l2_d[l][2*j];
                    l2_i[l+1][j] = l2_i[l][2*j];
                end
            end
        end
        match_next.item     = it5_reg;
        match_next.exact    = exact5_reg;
        match_next.best_d   = l2_d[LVLS-SPLIT][0];
        match_next.best_idx = l2_i[LVLS-SPLIT][0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (acc5)
            begin
                v5_reg <= up_valid;
            end
            if (acc6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc5 && up_valid)
        begin
            it5_reg    <= up_item;
            exact5_reg <= up_exact;
            mid_d_reg  <= mid_d_next;
            mid_i_reg  <= mid_i_next;
        end
        if (acc6 && v5_reg)
        begin
            match_reg <= match_next;
        end
    end

    assign down_valid = v6_reg;
    assign down_match = match_reg;

endmodule

[tb/sv/tb.sv]
module tb
    import pcrm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam op_t OP_UNUSED = op_t'(2'd3);
    localparam int  LONG_HOLD = 250;
    localparam int  SETTLE    = 12;
    localparam int  PHASE_LEN = 290;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        logic  hit;
    } recolor_t;

    class recolor_model;
        rgb_t        base_colors[ENTRIES];
        rgb_t        new_colors[ENTRIES];
        int unsigned max_dist;
        recolor_t    expected_colors[$];
        int          mismatches;

        function new();
            foreach (base_colors[i])
            begin
                base_colors[i] = '0;
                new_colors[i]  = '0;
            end
            max_dist   = 32'(MAX_DIST_RST);
            mismatches = 0;
        endfunction

        function int unsigned color_dist_sq(rgb_t a, rgb_t b);
            int unsigned sum;
            int          d;
            sum = 0;
            for (int c = 0; c < 3; c++)
            begin
                d   = int'(a[c*CH_W +: CH_W]) - int'(b[c*CH_W +: CH_W]);
                sum += d * d;
            end
            return sum;
        endfunction

        function void add_expected(recolor_t r);
            expected_colors = {expected_colors, r};
        endfunction

        function void note_pixel(item_t p);
            rgb_t        res;
            logic        hit;
            int          best;
            int unsigned best_d;
            int unsigned d;
            res = p.rgb;
            hit = 1'b0;
            case (p.op)
                OP_WRITE:
                begin
                    if (int'(p.index) < ENTRIES)
                    begin
                        base_colors[p.index] = p.rgb;
                        new_colors[p.index]  = p.new_rgb;
                    end
                    return;
                end
                OP_EXACT:
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (!hit && base_colors[i] == p.rgb)
                        begin
                            res = new_colors[i];
                            hit = 1'b1;
                        end
                    end
                end
                OP_NEAR:
                begin
                    best   = 0;
                    best_d = color_dist_sq(base_colors[0], p.rgb);
                    for (int i = 1; i < ENTRIES; i++)
                    begin
                        d = color_dist_sq(base_colors[i], p.rgb);
                        if (d < best_d)
                        begin
                            best_d = d;
                            best   = i;
                        end
                    end
                    if (best_d <= max_dist * max_dist)
                    begin
                        res = new_colors[best];
                        hit = 1'b1;
                    end
                end
                default:
                begin
                    return;
                end
            endcase
            add_expected({res, hit});
        endfunction

        function void check_result(recolor_t got);
            recolor_t want;
            if (expected_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result r=%h g=%h b=%h hit=%b",
                             got.red, got.green, got.blue, got.hit);
                end
                return;
            end
            want = expected_colors.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.hit !== want.hit)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result mismatch: expected r=%h g=%h b=%h hit=%b, got r=%h g=%h b=%h hit=%b",
                             want.red, want.green, want.blue, want.hit,
                             got.red, got.green, got.blue, got.hit);
                end
            end
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pcrm_in_if  pix_if ();
    pcrm_out_if res_if ();
    pcrm_cfg_if cfg_if ();

    palette_color_replace_match i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    recolor_model model;
    bit           calm;
    int           hold_off_cycles;
    int           stall_left;
    item_t        directed_items[$];

    always #1 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 0;
        end
        if (r < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 30);
    endfunction

    function automatic item_t mk(op_t op, logic [3:0] index, rgb_t rgb, rgb_t new_rgb);
        item_t it;
        it.op      = op;
        it.index   = index;
        it.rgb     = rgb;
        it.new_rgb = new_rgb;
        return it;
    endfunction

    function automatic void add_directed(item_t it);
        directed_items = {directed_items, it};
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int    pick;
        int    e;
        int    spread;
        int    v;
        rgb_t  anchor;
        it.index   = FIELD_IDX_W'($urandom);
        it.rgb     = RGB_W'($urandom);
        it.new_rgb = RGB_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            it.op = OP_WRITE;
            if ($urandom_range(0, 4) == 0)
            begin
                it.rgb = model.base_colors[$urandom_range(0, ENTRIES - 1)];
            end
        end
        else if (pick < 15)
        begin
            it.op = OP_UNUSED;
        end
        else
        begin
            it.op = (pick < 45) ? OP_EXACT : OP_NEAR;
            if ($urandom_range(0, 3) != 0)
            begin
                e      = $urandom_range(0, ENTRIES - 1);
                anchor = model.base_colors[e];
                spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (it.op == OP_EXACT && $urandom_range(0, 1) == 0)
                begin
                    spread = 0;
                end
                for (int c = 0; c < 3; c++)
                begin
                    v = int'(anchor[c*CH_W +: CH_W]) + int'($urandom_range(0, 2 * spread))
                        - spread;
                    if (v < 0)
                    begin
                        v = 0;
                    end
                    if (v > 255)
                    begin
                        v = 255;
                    end
                    it.rgb[c*CH_W +: CH_W] = v[CH_W-1:0];
                end
            end
        end
        return it;
    endfunction

    task automatic send_pixel(item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid     <= 1'b1;
        pix_if.op        <= it.op;
        pix_if.index     <= it.index;
        pix_if.red       <= it.rgb[23:16];
        pix_if.green     <= it.rgb[15:8];
        pix_if.blue      <= it.rgb[7:0];
        pix_if.new_red   <= it.new_rgb[23:16];
        pix_if.new_green <= it.new_rgb[15:8];
        pix_if.new_blue  <= it.new_rgb[7:0];
        do @(posedge clk); while (!pix_if.ready);
        model.note_pixel(it);
    endtask

    task automatic write_max_distance(chan_t value);
        cfg_if.valid        <= 1'b1;
        cfg_if.max_distance <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        model.max_dist = 32'(value);
    endtask

    task automatic drain();
        while (model.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // result side: random stalls plus the long hold-off
    initial
    begin
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid && res_if.ready)
            begin
                model.check_result({res_if.out_red, res_if.out_green, res_if.out_blue,
                                    res_if.hit});
            end
            if (hold_off_cycles > 0)
            begin
                stall_left      = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        chan_t settings[6];

        pix_if.valid        = 1'b0;
        pix_if.op           = OP_WRITE;
        pix_if.index        = '0;
        pix_if.red          = '0;
        pix_if.green        = '0;
        pix_if.blue         = '0;
        pix_if.new_red      = '0;
        pix_if.new_green    = '0;
        pix_if.new_blue     = '0;
        res_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.max_distance = '0;
        calm                = 1'b0;
        hold_off_cycles     = 0;
        model               = new();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fresh table: black hits entry 0, nearest edge of the reset radius
        add_directed(mk(OP_EXACT, 4'h0, 24'h000000, 24'h000000));
        add_directed(mk(OP_NEAR,  4'h0, 24'h030405, 24'h000000));
        add_directed(mk(OP_NEAR,  4'h0, 24'h080000, 24'h000000));
        add_directed(mk(OP_NEAR,  4'h0, 24'h080100, 24'h000000));
        add_directed(mk(OP_EXACT, 4'h0, 24'h010000, 24'h000000));
        add_directed(mk(OP_UNUSED, 4'hf, 24'hffffff, 24'hffffff));
        add_directed(mk(OP_WRITE, 4'h0, 24'hffffff, 24'h123456));
        add_directed(mk(OP_WRITE, 4'hf, 24'h000000, 24'hffffff));
        // duplicate base colors, lowest entry wins
        add_directed(mk(OP_WRITE, 4'h5, 24'h804020, 24'haa55aa));
        add_directed(mk(OP_WRITE, 4'ha, 24'h804020, 24'h55aa55));
        add_directed(mk(OP_EXACT, 4'h0, 24'h804020, 24'h000000));
        add_directed(mk(OP_NEAR,  4'h0, 24'h82411f, 24'h000000));
        add_directed(mk(OP_EXACT, 4'h0, 24'hffffff, 24'h000000));
        add_directed(mk(OP_NEAR,  4'h0, 24'hfafafa, 24'h000000));
        add_directed(mk(OP_NEAR,  4'h0, 24'hfbfcfd, 24'h000000));
        add_directed(mk(OP_EXACT, 4'h0, 24'h000000, 24'h000000));
        add_directed(mk(OP_EXACT, 4'hf, 24'hffffff, 24'hffffff));
        add_directed(mk(OP_WRITE, 4'h3, 24'h7f7f7f, 24'h000000));
        add_directed(mk(OP_NEAR,  4'h0, 24'h808080, 24'h000000));
        add_directed(mk(OP_UNUSED, 4'h0, 24'h000000, 24'h000000));
        add_directed(mk(OP_NEAR,  4'hf, 24'hffffff, 24'hffffff));
        foreach (directed_items[i])
        begin
            send_pixel(directed_items[i]);
        end
        pix_if.valid <= 1'b0;
        drain();

        settings[0] = 8'd0;
        settings[1] = 8'd255;
        settings[2] = CH_W'($urandom_range(1, 40));
        settings[3] = CH_W'($urandom_range(1, 40));
        settings[4] = 8'd1;
        settings[5] = 8'd8;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_max_distance(settings[ph]);
            calm = (ph == 3);
            if (ph == 1)
            begin
                hold_off_cycles = LONG_HOLD;
            end
            repeat (PHASE_LEN) send_pixel(rand_item());
            pix_if.valid <= 1'b0;
            drain();
        end

        if (model.mismatches == 0 && model.pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[palette_color_replace_match.f]
hdl/pcrm_pkg.sv
hdl/pcrm_if.sv
hdl/pcrm_lanes.sv
hdl/pcrm_min_tree.sv
hdl/palette_color_replace_match.sv
tb/sv/tb.sv
